// ===== rtl/core/tams_pkg.sv =====
package tams_pkg;

	// Compare values loaded into the PWM channels while a motor runs.
	localparam logic [9:0]  DUTY_ROT   = 10'd500;
	localparam logic [10:0] DUTY_UP    = 11'd1000;
	localparam logic [10:0] DUTY_DOWN  = 11'd1500;
	localparam logic [9:0]  DUTY_WRIST = 10'd900;

	// Reset values of the target registers.
	localparam logic [15:0] WRIST_HOME_RST = 16'd10000;
	localparam logic [15:0] WRIST_MID_RST  = 16'd5000;
	localparam logic [15:0] WRIST_FAR_RST  = 16'd60000;
	localparam logic [31:0] ROT_A_RST      = 32'd100000;
	localparam logic [31:0] ROT_B_RST      = 32'd150000;
	localparam logic [31:0] LIN_DOWN_RST   = 32'd10000;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_WRIST_HOME = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WRIST_MID  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WRIST_FAR  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROT_A      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROT_B      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_LIN_DOWN   = 3'd5;

	// Mode codes as reported on mode_now.
	localparam logic [1:0] MODE_CODE_HOME = 2'd0;
	localparam logic [1:0] MODE_CODE_CYC1 = 2'd1;
	localparam logic [1:0] MODE_CODE_CYC2 = 2'd2;

	typedef enum logic [2:0] {
		MODE_HOME = 3'b001,
		MODE_CYC1 = 3'b010,
		MODE_CYC2 = 3'b100
	} mode_t;

	// Direction A is rotation left, lift up, wrist left; B is the opposite.
	typedef enum logic [1:0] {
		MOTOR_OFF = 2'd0,
		MOTOR_A   = 2'd1,
		MOTOR_B   = 2'd2
	} motor_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  home_step;
		logic [2:0]  cycle1_step;
		logic [2:0]  cycle2_step;
	} seq_state_t;

	typedef struct packed {
		logic [15:0] wrist_home;
		logic [15:0] wrist_mid;
		logic [15:0] wrist_far;
		logic [31:0] rot_a;
		logic [31:0] rot_b;
		logic [31:0] lin_down;
	} targets_t;

	// One poll tick with the sensors and buttons already made active high.
	typedef struct packed {
		logic [31:0] rot_count;
		logic [31:0] lin_count;
		logic [15:0] wrist_count;
		logic        s1;
		logic        s2;
		logic        s3;
		logic        s4;
		logic        b1;
		logic        b2;
		logic        b3;
	} poll_t;

	typedef struct packed {
		motor_t      rot;
		motor_t      lift;
		motor_t      wrist;
		logic        clear_rot;
		logic        clear_lin;
		logic [1:0]  mode_code;
		logic [2:0]  step;
	} tick_result_t;

endpackage

// ===== rtl/core/three_axis_motion_sequencer.sv =====
// Three-axis motion sequencer. Every input beat is one poll tick (three encoder
// counts, four active-low limit sensors, three active-low buttons) and yields
// exactly one output beat: the PWM compare values of the rotation, lift and wrist
// H-bridges for the step that ran on that tick, the counter clear pulses, and the
// mode and step that ran. The block accepts a new beat in every cycle when in_stall
// is low, and each result is registered in the cycle after its beat is taken. The
// single-cycle rate comes from the step and mode update, which reads the state
// written by the previous beat, so the whole decision sits between the input
// ports and one result register. in_stall rises only while the result register
// holds a beat that the downstream side is stalling. The six target registers
// take a write on any cycle (cfg_ready is always high) and are meant to be changed
// only while no beat is in flight; writes to indexes beyond the list are dropped.
module three_axis_motion_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tams_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [31:0]                        cfg_data,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [31:0]                        rot_count,
	input  logic [31:0]                        lin_count,
	input  logic [15:0]                        wrist_count,
	input  logic                               sensor_1_n,
	input  logic                               sensor_2_n,
	input  logic                               sensor_3_n,
	input  logic                               sensor_4_n,
	input  logic                               button_1_n,
	input  logic                               button_2_n,
	input  logic                               button_3_n,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [9:0]                         rot_left_duty,
	output logic [9:0]                         rot_right_duty,
	output logic [10:0]                        lift_up_duty,
	output logic [10:0]                        lift_down_duty,
	output logic [9:0]                         wrist_left_duty,
	output logic [9:0]                         wrist_right_duty,
	output logic                               clear_rot,
	output logic                               clear_lin,
	output logic [1:0]                         mode_now,
	output logic [2:0]                         step_now
);
	import tams_pkg::*;

	seq_state_t   state_q;
	seq_state_t   state_next;
	targets_t     targets_q;
	poll_t        poll;
	tick_result_t res;
	logic         in_accept;

	// Configuration writes never wait.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			targets_q.wrist_home <= WRIST_HOME_RST;
			targets_q.wrist_mid  <= WRIST_MID_RST;
			targets_q.wrist_far  <= WRIST_FAR_RST;
			targets_q.rot_a      <= ROT_A_RST;
			targets_q.rot_b      <= ROT_B_RST;
			targets_q.lin_down   <= LIN_DOWN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WRIST_HOME: targets_q.wrist_home <= cfg_data[15:0];
				CFG_WRIST_MID:  targets_q.wrist_mid  <= cfg_data[15:0];
				CFG_WRIST_FAR:  targets_q.wrist_far  <= cfg_data[15:0];
				CFG_ROT_A:      targets_q.rot_a      <= cfg_data;
				CFG_ROT_B:      targets_q.rot_b      <= cfg_data;
				CFG_LIN_DOWN:   targets_q.lin_down   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The sensors and buttons are active low; the step logic works active high.
	assign poll.rot_count   = rot_count;
	assign poll.lin_count   = lin_count;
	assign poll.wrist_count = wrist_count;
	assign poll.s1          = ~sensor_1_n;
	assign poll.s2          = ~sensor_2_n;
	assign poll.s3          = ~sensor_3_n;
	assign poll.s4          = ~sensor_4_n;
	assign poll.b1          = ~button_1_n;
	assign poll.b2          = ~button_2_n;
	assign poll.b3          = ~button_3_n;

	tams_step u_step (
		.st      (state_q),
		.tgt     (targets_q),
		.poll    (poll),
		.st_next (state_next),
		.res     (res)
	);

	// A beat is taken whenever the result register is empty or is being
	// emptied in the same cycle.
	assign in_stall  = out_valid & out_stall;
	assign in_accept = in_valid & ~in_stall;

	// The mode and all three step counters move only on an accepted beat.
	// Sequences that are not running keep their step untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= MODE_HOME;
			state_q.home_step   <= 2'd0;
			state_q.cycle1_step <= 3'd0;
			state_q.cycle2_step <= 3'd0;
		end else if (in_accept) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Result register: the motor commands are turned into compare values here.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			rot_left_duty    <= (res.rot == MOTOR_A)   ? DUTY_ROT   : 10'd0;
			rot_right_duty   <= (res.rot == MOTOR_B)   ? DUTY_ROT   : 10'd0;
			lift_up_duty     <= (res.lift == MOTOR_A)  ? DUTY_UP    : 11'd0;
			lift_down_duty   <= (res.lift == MOTOR_B)  ? DUTY_DOWN  : 11'd0;
			wrist_left_duty  <= (res.wrist == MOTOR_A) ? DUTY_WRIST : 10'd0;
			wrist_right_duty <= (res.wrist == MOTOR_B) ? DUTY_WRIST : 10'd0;
			clear_rot        <= res.clear_rot;
			clear_lin        <= res.clear_lin;
			mode_now         <= res.mode_code;
			step_now         <= res.step;
		end
	end

endmodule

// ===== rtl/core/tams_step.sv =====
module tams_step (
	input  tams_pkg::seq_state_t   st,
	input  tams_pkg::targets_t     tgt,
	input  tams_pkg::poll_t        poll,
	output tams_pkg::seq_state_t   st_next,
	output tams_pkg::tick_result_t res
);
	import tams_pkg::*;

	always_comb begin
		st_next       = st;
		res.rot       = MOTOR_OFF;
		res.lift      = MOTOR_OFF;
		res.wrist     = MOTOR_OFF;
		res.clear_rot = 1'b0;
		res.clear_lin = 1'b0;
		res.mode_code = MODE_CODE_HOME;
		res.step      = {1'b0, st.home_step};

		case (st.mode)
			MODE_CYC1: begin
				res.mode_code = MODE_CODE_CYC1;
				res.step      = st.cycle1_step;
				case (st.cycle1_step)
					3'd0: begin
						res.rot = MOTOR_B;
						if (poll.s2) st_next.cycle1_step = 3'd1;
					end
					3'd1: begin
						res.lift = MOTOR_A;
						if (poll.s4) st_next.cycle1_step = 3'd2;
					end
					3'd2: begin
						res.wrist = MOTOR_B;
						if (poll.wrist_count == tgt.wrist_mid) st_next.cycle1_step = 3'd3;
					end
					3'd3: st_next.cycle1_step = 3'd4;
					3'd4: begin
						res.wrist = MOTOR_A;
						if (poll.wrist_count == tgt.wrist_far) st_next.cycle1_step = 3'd5;
					end
					3'd5: begin
						res.lift = MOTOR_B;
						if (poll.s3) st_next.cycle1_step = 3'd6;
					end
					3'd6: begin
						res.rot = MOTOR_A;
						if (poll.s1) st_next.cycle1_step = 3'd0;
					end
					default: st_next.cycle1_step = 3'd0;
				endcase
				if (poll.b3) st_next.mode = MODE_HOME;
			end
			MODE_CYC2: begin
				res.mode_code = MODE_CODE_CYC2;
				res.step      = st.cycle2_step;
				case (st.cycle2_step)
					3'd0: begin
						res.rot = MOTOR_A;
						if (poll.rot_count == tgt.rot_a) st_next.cycle2_step = 3'd1;
					end
					3'd1: begin
						res.lift = MOTOR_A;
						if (poll.s4) st_next.cycle2_step = 3'd2;
					end
					3'd2: begin
						res.wrist = MOTOR_A;
						if (poll.wrist_count == tgt.wrist_far) st_next.cycle2_step = 3'd3;
					end
					3'd3: begin
						res.rot = MOTOR_A;
						if (poll.rot_count == tgt.rot_b) st_next.cycle2_step = 3'd4;
					end
					3'd4: begin
						res.lift = MOTOR_B;
						if (poll.lin_count == tgt.lin_down) st_next.cycle2_step = 3'd5;
					end
					3'd5: begin
						res.lift = MOTOR_B;
						if (poll.lin_count == 32'd0) st_next.cycle2_step = 3'd6;
					end
					3'd6: begin
						res.wrist = MOTOR_B;
						if (poll.wrist_count == 16'd0) st_next.cycle2_step = 3'd7;
					end
					default: begin
						res.rot = MOTOR_B;
						if (poll.rot_count == tgt.rot_a) st_next.cycle2_step = 3'd0;
					end
				endcase
				if (poll.b3) st_next.mode = MODE_HOME;
			end
			default: begin
				case (st.home_step)
					2'd0: begin
						res.rot = MOTOR_B;
						if (poll.s1) begin
							res.clear_rot     = 1'b1;
							st_next.home_step = 2'd1;
						end
					end
					2'd1: begin
						res.lift = MOTOR_B;
						if (poll.s3) begin
							res.clear_lin     = 1'b1;
							st_next.home_step = 2'd2;
						end
					end
					2'd2: begin
						res.wrist = MOTOR_A;
						if (poll.wrist_count == tgt.wrist_home) st_next.home_step = 2'd3;
					end
					default: begin
						if (poll.b3) st_next.home_step = 2'd0;
					end
				endcase
				// Cycle two wins when both start buttons are pressed.
				st_next.mode = MODE_HOME;
				if (poll.b1) st_next.mode = MODE_CYC1;
				if (poll.b2) st_next.mode = MODE_CYC2;
			end
		endcase
	end

endmodule
